### hdl/bdte_pkg.sv
// Shared types and constants for the BCD date/time to epoch seconds block.
// No dependencies; imported by bdte_terms, bdte_apb and the core module.
`default_nettype none

package bdte_pkg;

    // Item commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Configuration register word index, taken from paddr[2]
    localparam logic REG_EPOCH_OFFSET = 1'b0;

    localparam logic [31:0] SECS_PER_YEAR = 32'd31536000;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;

    localparam int MONTHS = 12;
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

    // Cumulative seconds before each month of a common year
    localparam logic [24:0] MONTH_START [MONTHS] = '{
        25'd0,        25'd2678400,  25'd5097600,  25'd7776000,
        25'd10368000, 25'd13046400, 25'd15638400, 25'd18316800,
        25'd20995200, 25'd23587200, 25'd26265600, 25'd28857600
    };

    // Partial sums handed from the conversion logic to the final adder
    typedef struct packed {
        logic [31:0] year_term;       // year * seconds per year, wrapped
        logic [25:0] month_day_term;  // month start plus whole days
        logic [19:0] hms_term;        // hours, minutes and seconds
    } calc_terms_t;

    // Apply the BCD fix-up x - 6*(x>>4); never goes negative for 8-bit x
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] x);
        logic [7:0] adj;
        adj = 8'({4'd0, x[7:4]} * 8'd6);
        return x - adj;
    endfunction

endpackage

`default_nettype wire

### hdl/bdte_terms.sv
// Calendar conversion: BCD fields to partial seconds terms.
// Depends on bdte_pkg.
`default_nettype none

module bdte_terms (
    input  wire logic [7:0]          bcd_year,
    input  wire logic [7:0]          bcd_month,
    input  wire logic [7:0]          bcd_day,
    input  wire logic [7:0]          bcd_hours,
    input  wire logic [7:0]          bcd_minutes,
    input  wire logic [7:0]          bcd_seconds,
    output bdte_pkg::calc_terms_t    terms
);
    import bdte_pkg::*;

    logic [7:0]  year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [7:0]  month_fix;
    logic [7:0]  day_fix;
    logic [3:0]  month_idx;
    logic        extra_day;
    logic [7:0]  day_count;

    always_comb
    begin
        year    = bcd_to_bin(bcd_year);
        month   = bcd_to_bin(bcd_month);
        day     = bcd_to_bin(bcd_day);
        hours   = bcd_to_bin(bcd_hours);
        minutes = bcd_to_bin(bcd_minutes);
        seconds = bcd_to_bin(bcd_seconds);

        month_fix = (month == 8'd0) ? 8'd1 : month;
        day_fix   = (day == 8'd0) ? 8'd1 : day;

        // Saturate months beyond December
        if (month_fix > 8'd12)
        begin
            month_idx = LAST_MONTH_IDX;
        end
        else
        begin
            month_idx = 4'(month_fix - 8'd1);
        end

        extra_day = (year != 8'd0) || (month_fix >= 8'd3);
        // At most 165 after the fix-up, so the extra day cannot overflow
        day_count = day_fix - 8'd1 + {7'd0, extra_day};

        terms.year_term      = 32'({24'd0, year} * SECS_PER_YEAR);
        terms.month_day_term = 26'({7'd0, MONTH_START[month_idx]}
                                   + {24'd0, day_count} * SECS_PER_DAY);
        terms.hms_term       = 20'({24'd0, hours} * SECS_PER_HOUR
                                   + {24'd0, minutes} * SECS_PER_MIN
                                   + {24'd0, seconds});
    end

endmodule

`default_nettype wire

### hdl/bdte_apb.sv
// APB configuration register: the epoch offset.
// Depends on bdte_pkg.
`default_nettype none

module bdte_apb (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [31:0]      epoch_offset
);
    import bdte_pkg::*;

    logic [31:0] epoch_offset_reg;
    logic [31:0] epoch_offset_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        epoch_offset_next = epoch_offset_reg;
        if (wr_en && (paddr[2] == REG_EPOCH_OFFSET))
        begin
            epoch_offset_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_offset_reg <= '0;
        end
        else
        begin
            epoch_offset_reg <= epoch_offset_next;
        end
    end

    // Bits [1:0] are ignored; unmapped words read as zero
    assign prdata = (paddr[2] == REG_EPOCH_OFFSET) ? epoch_offset_reg : '0;
    assign epoch_offset = epoch_offset_reg;

endmodule

`default_nettype wire

### hdl/bcd_datetime_to_epoch_seconds_core.sv
// BCD calendar snapshot to seconds since 2000, with a running seconds counter.
//
// Input channel (in_valid/in_ready) carries cmd and six BCD calendar fields.
// cmd LOAD converts the snapshot, adds the epoch offset and restarts the
// time from that value; TICK adds one second; READ (and the unused code)
// leave the time alone. Every transfer yields one result, time_value, on the
// output channel (out_valid/out_ready), in order.
// Three register stages: input register, partial-terms register, result
// register; an accepted item passes through them in that order. One item
// is taken every cycle while the receiver keeps up; the running time lives
// in the result stage, so a tick or load right behind another is handled
// without bubbles.
// When the receiver stalls, the result holds and the stages behind it fill;
// in_ready drops only once all three are occupied.
// Reset clears the time, the offset register and all valid flags.
// The epoch offset (APB word 0) is to be written while no item is in flight.
// Depends on bdte_pkg, bdte_terms and bdte_apb.
`default_nettype none

module bcd_datetime_to_epoch_seconds_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  bcd_year,
    input  wire logic [7:0]  bcd_month,
    input  wire logic [7:0]  bcd_day,
    input  wire logic [7:0]  bcd_hours,
    input  wire logic [7:0]  bcd_minutes,
    input  wire logic [7:0]  bcd_seconds,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      time_value,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bdte_pkg::*;

    logic [31:0] epoch_offset;

    // Stage 1: input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_cmd_reg;
    logic [7:0]  s1_year_reg;
    logic [7:0]  s1_month_reg;
    logic [7:0]  s1_day_reg;
    logic [7:0]  s1_hours_reg;
    logic [7:0]  s1_minutes_reg;
    logic [7:0]  s1_seconds_reg;

    // Stage 2: partial terms
    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic [1:0]  s2_cmd_reg;
    calc_terms_t s2_terms_reg;
    calc_terms_t s1_terms;

    // Stage 3: result register and running time
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] time_reg;
    logic [31:0] time_next;
    logic [31:0] load_sum;

    logic        s3_ready;
    logic        s2_ready;
    logic        s1_load;
    logic        s2_load;
    logic        s3_load;

    bdte_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .epoch_offset (epoch_offset)
    );

    bdte_terms u_terms (
        .bcd_year    (s1_year_reg),
        .bcd_month   (s1_month_reg),
        .bcd_day     (s1_day_reg),
        .bcd_hours   (s1_hours_reg),
        .bcd_minutes (s1_minutes_reg),
        .bcd_seconds (s1_seconds_reg),
        .terms       (s1_terms)
    );

    assign s3_ready = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = !s1_valid_reg || s2_ready;

    assign s1_load = in_valid && in_ready;
    assign s2_load = s1_valid_reg && s2_ready;
    assign s3_load = s2_valid_reg && s3_ready;

    always_comb
    begin
        s1_valid_next  = s1_load || (s1_valid_reg && !s2_ready);
        s2_valid_next  = s2_load || (s2_valid_reg && !s3_ready);
        out_valid_next = s3_load || (out_valid_reg && !out_ready);
    end

    assign load_sum = epoch_offset + s2_terms_reg.year_term
                    + {6'd0, s2_terms_reg.month_day_term}
                    + {12'd0, s2_terms_reg.hms_term};

    // Advance the running time as each item enters the result stage
    always_comb
    begin
        time_next = time_reg;
        if (s3_load)
        begin
            unique case (s2_cmd_reg)
                CMD_LOAD: time_next = load_sum;
                CMD_TICK: time_next = time_reg + 32'd1;
                CMD_READ: time_next = time_reg;
                default:  time_next = time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            time_reg      <= time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cmd_reg     <= cmd;
            s1_year_reg    <= bcd_year;
            s1_month_reg   <= bcd_month;
            s1_day_reg     <= bcd_day;
            s1_hours_reg   <= bcd_hours;
            s1_minutes_reg <= bcd_minutes;
            s1_seconds_reg <= bcd_seconds;
        end
        if (s2_load)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_terms_reg <= s1_terms;
        end
    end

    // The time only changes when a new item enters, so it doubles as the result
    assign out_valid  = out_valid_reg;
    assign time_value = time_reg;

endmodule

`default_nettype wire

### hdl/bdte_checker.sv
// Port-level checks for bcd_datetime_to_epoch_seconds_core, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module bdte_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] time_value,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(time_value))
        else $error("result changed while stalled");

    // With the result stage empty the whole pipeline can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result stage");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    // A written offset reads back on the following cycle
    a_offset_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2]
        |=> paddr[2] || (prdata == $past(pwdata)))
        else $error("epoch offset readback mismatch");

endmodule

bind bcd_datetime_to_epoch_seconds_core bdte_checker u_bdte_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .time_value (time_value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for bcd_datetime_to_epoch_seconds_core: queued stimulus, a
// clocked driver and monitor, and a built-in prediction of every time_value.
// Depends on bdte_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;

    import bdte_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;     // unused code, behaves as a read
    localparam logic [2:0] ADDR_EPOCH_OFFSET = {REG_EPOCH_OFFSET, 2'b00};
    localparam int unsigned YEAR_SECS = 31536000;
    localparam int unsigned DAY_SECS = 86400;
    localparam int unsigned HOUR_SECS = 3600;
    localparam int unsigned MIN_SECS = 60;
    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int LONG_STALL = 64;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } datetime_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_READ;
    logic [7:0]  bcd_year = 8'h00;
    logic [7:0]  bcd_month = 8'h00;
    logic [7:0]  bcd_day = 8'h00;
    logic [7:0]  bcd_hours = 8'h00;
    logic [7:0]  bcd_minutes = 8'h00;
    logic [7:0]  bcd_seconds = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] time_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    datetime_item_t pending_items[$];
    logic [31:0]    expected_times[$];

    // Predicted block state
    logic [31:0] pred_offset = 32'd0;
    logic [31:0] pred_epoch = 32'd0;
    logic [31:0] pred_ticks = 32'd0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_asked = 0;
    int stall_granted = 0;
    int stall_left = 0;
    int mismatches = 0;

    bcd_datetime_to_epoch_seconds_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .bcd_year    (bcd_year),
        .bcd_month   (bcd_month),
        .bcd_day     (bcd_day),
        .bcd_hours   (bcd_hours),
        .bcd_minutes (bcd_minutes),
        .bcd_seconds (bcd_seconds),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .time_value  (time_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Decimal fix-up with no digit check, wrapped to a byte
    function automatic logic [31:0] bcd_value(logic [7:0] raw);
        int unsigned x;
        x = raw;
        return (x - 6 * (x >> 4)) & 32'hFF;
    endfunction

    function automatic logic [31:0] calendar_seconds(datetime_item_t it);
        logic [31:0] yr;
        logic [31:0] mo;
        logic [31:0] dy;
        logic [31:0] sum;
        int          month_idx;
        yr = bcd_value(it.year);
        mo = bcd_value(it.month);
        dy = bcd_value(it.day);
        if (mo == 0)
            mo = 1;
        if (dy == 0)
            dy = 1;
        month_idx = (mo - 1 >= 12) ? 11 : int'(mo - 1);
        sum = pred_offset + yr * YEAR_SECS + (dy - 1) * DAY_SECS
            + bcd_value(it.hours) * HOUR_SECS + bcd_value(it.minutes) * MIN_SECS
            + bcd_value(it.seconds);
        for (int m = 0; m < month_idx; m++)
            sum += DAYS_IN_MONTH[m] * DAY_SECS;
        // single leap allowance: any nonzero year, or March onwards in year zero
        if (yr != 0 || mo >= 3)
            sum += DAY_SECS;
        return sum;
    endfunction

    // Advance the predicted state by one item and return its time_value
    function automatic logic [31:0] next_time_value(datetime_item_t it);
        if (it.op == CMD_LOAD)
        begin
            pred_epoch = calendar_seconds(it);
            pred_ticks = 32'd0;
        end
        else if (it.op == CMD_TICK)
            pred_ticks = pred_ticks + 32'd1;
        return pred_epoch + pred_ticks;
    endfunction

    function automatic logic [7:0] to_bcd(int unsigned n);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    function automatic datetime_item_t random_item();
        datetime_item_t it;
        int unsigned    pick;
        it = datetime_item_t'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            it.op = CMD_LOAD;
            it.year = to_bcd($urandom_range(99));
            it.month = to_bcd($urandom_range(12, 1));
            it.day = to_bcd($urandom_range(31, 1));
            it.hours = to_bcd($urandom_range(23));
            it.minutes = to_bcd($urandom_range(59));
            it.seconds = to_bcd($urandom_range(59));
        end
        else if (pick < 55)
            it.op = CMD_LOAD;          // raw bytes, invalid digits included
        else if (pick < 85)
            it.op = CMD_TICK;
        else if (pick < 95)
            it.op = CMD_READ;
        else
            it.op = CMD_SPARE;
        return it;
    endfunction

    task automatic push_load(logic [7:0] y, logic [7:0] mo, logic [7:0] d,
                             logic [7:0] h, logic [7:0] mi, logic [7:0] s);
        pending_items.push_back('{CMD_LOAD, y, mo, d, h, mi, s});
    endtask

    task automatic push_op(logic [1:0] op);
        pending_items.push_back('{op, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    task automatic push_random(int count);
        repeat (count) pending_items.push_back(random_item());
    endtask

    // Hold the stimulus until every transfer has been answered
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_times.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_offset(logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_EPOCH_OFFSET;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pred_offset = value;
    endtask

    // Sender: predict on each accepted transfer, then offer the next item
    always @(posedge clk)
    begin : sender
        datetime_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_times.push_back(next_time_value('{cmd, bcd_year, bcd_month,
                    bcd_day, bcd_hours, bcd_minutes, bcd_seconds}));
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    cmd <= nxt.op;
                    bcd_year <= nxt.year;
                    bcd_month <= nxt.month;
                    bcd_day <= nxt.day;
                    bcd_hours <= nxt.hours;
                    bcd_minutes <= nxt.minutes;
                    bcd_seconds <= nxt.seconds;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus long hold-offs on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_asked != stall_granted)
            begin
                stall_granted <= stall_asked;
                stall_left <= LONG_STALL;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_times.size() == 0)
            begin
                $display("%0t: unexpected time_value transfer, expected none actual %08h",
                         $time, time_value);
                mismatches++;
            end
            else if (time_value !== expected_times[0])
            begin
                $display("%0t: time_value mismatch, expected %08h actual %08h",
                         $time, expected_times[0], time_value);
                mismatches++;
                void'(expected_times.pop_front());
            end
            else
                void'(expected_times.pop_front());
        end
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 34;
        recv_idle_pct = 88;
        write_offset(32'd0);
        push_load(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // zero month and day
        push_op(CMD_READ);
        push_op(CMD_TICK);
        push_op(CMD_TICK);
        push_op(CMD_SPARE);
        push_op(CMD_READ);
        push_load(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
        push_load(8'h00, 8'h02, 8'h29, 8'h23, 8'h59, 8'h59);   // year zero, before March
        push_load(8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00);   // year zero, March
        push_load(8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
        push_load(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59);
        push_op(CMD_TICK);
        push_load(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // bad digits, wraps
        push_op(CMD_TICK);
        push_load(8'h00, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00);   // month past December
        push_load(8'h00, 8'h0A, 8'h0F, 8'h0B, 8'h0C, 8'h0D);   // bad low digits
        push_load(8'hA5, 8'h1F, 8'h3C, 8'h9A, 8'hF0, 8'h6E);
        push_load(8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04);
        push_op(CMD_TICK);
        push_op(CMD_READ);
        push_op(CMD_SPARE);
        push_op(CMD_TICK);
        drain();

        write_offset(32'hFFFF_FFFF);
        push_random(140);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 34;
        write_offset($urandom);
        push_random(140);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_offset(32'h8000_0000);
        push_random(70);
        stall_asked = stall_asked + 1;   // block fills and drops in_ready
        drain();
        push_random(70);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hdl/bdte_pkg.sv
hdl/bdte_terms.sv
hdl/bdte_apb.sv
hdl/bcd_datetime_to_epoch_seconds_core.sv
hdl/bdte_checker.sv
tb/sv/tb_top.sv
